@@ hdl/mbr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mbr_pkg;

  // store geometry
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned POS_W       = ADDR_W + 1;
  localparam int unsigned MAX_BITS    = 64;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned NEED_W      = POS_W + 4;
  localparam int unsigned ACC_W       = MAX_BITS + 8;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // raw op codes on the input
  localparam logic [2:0] OPC_APPEND = 3'd0;
  localparam logic [2:0] OPC_READ   = 3'd1;
  localparam logic [2:0] OPC_PEEK   = 3'd2;
  localparam logic [2:0] OPC_SKIP   = 3'd3;
  localparam logic [2:0] OPC_ALIGN  = 3'd4;
  localparam logic [2:0] OPC_CLEAR  = 3'd5;

  // decoded command kind
  typedef enum logic [2:0] {
    K_APPEND = 3'd0,
    K_READ   = 3'd1,
    K_PEEK   = 3'd2,
    K_SKIP   = 3'd3,
    K_ALIGN  = 3'd4,
    K_CLEAR  = 3'd5,
    K_NOP    = 3'd6
  } kind_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [7:0]       byte_in;
    logic [CNT_W-1:0] bit_count;
    logic [1:0]       align_log2;
  } mbr_in_t;

  typedef struct packed {
    logic [63:0]      value;
    logic [1:0]       status;
    logic [POS_W-1:0] byte_position;
    logic [2:0]       bit_offset;
    logic             at_end;
  } mbr_out_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       byte_in;
    logic [CNT_W-1:0] bit_count;
    logic [1:0]       align_log2;
  } mbr_cmd_t;

endpackage

`default_nettype wire

@@ hdl/msb_first_bit_reader.sv @@
`timescale 1ns / 1ps
`default_nettype none

// MSB-first bit reader over a 4096-byte store. Each input transaction
// (append, read, peek, skip, align, clear) yields exactly one result with
// the value, status, cursor and end flag. Items are decoded into a two-entry
// queue and executed one at a time. A successful read or peek of n bits
// starting at bit phase p fetches ceil((p + n) / 8) bytes, one per byte
// spanned, through the single registered read port of the byte store.
module msb_first_bit_reader
  import mbr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire mbr_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output mbr_out_t     out_data_o
);

  logic     cmd_vld, cmd_pop;
  mbr_cmd_t cmd;

  mbr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_vld_o  (cmd_vld),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  mbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_vld_i   (cmd_vld),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ hdl/mbr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbr_front
  import mbr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire mbr_in_t  in_data_i,
  output logic          cmd_vld_o,
  output mbr_cmd_t      cmd_o,
  input  wire logic     cmd_pop_i
);

  mbr_cmd_t    fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  mbr_cmd_t    dec;
  logic        push, pop;

  // classify the incoming transaction
  always_comb begin
    dec.byte_in    = in_data_i.byte_in;
    dec.bit_count  = in_data_i.bit_count;
    dec.align_log2 = in_data_i.align_log2;
    case (in_data_i.op)
      OPC_APPEND: dec.kind = K_APPEND;
      OPC_READ:   dec.kind = K_READ;
      OPC_PEEK:   dec.kind = K_PEEK;
      OPC_SKIP:   dec.kind = K_SKIP;
      OPC_ALIGN:  dec.kind = K_ALIGN;
      OPC_CLEAR:  dec.kind = K_CLEAR;
      default:    dec.kind = K_NOP;
    endcase
  end

  assign in_stall_o = cnt_q[1];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = cmd_pop_i && cmd_vld_o;
  assign cmd_vld_o  = cnt_q != 2'd0;
  assign cmd_o      = fifo_q[rp_q];

  // two entry command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= dec;
  end

endmodule

`default_nettype wire

@@ hdl/mbr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbr_back
  import mbr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_vld_i,
  input  wire mbr_cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output mbr_out_t      out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         mem [STORE_DEPTH];
  logic [POS_W-1:0]   len_q, len_d, pos_q, pos_d;
  logic [2:0]         ph_q, ph_d;
  logic [1:0]         stat_q, stat_d;
  logic [63:0]        val_q, val_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               move_q, move_d;
  logic [ACC_W-1:0]   acc_q;
  logic [3:0]         nb_q, nb_d, iss_q, rcv_q;
  logic               rd_vld_q;
  logic [7:0]         rd_data_q;
  logic               out_vld_q;
  mbr_out_t           out_q;
  logic               fetch_go;

  logic [NEED_W-1:0]  need, have, need_q;
  logic               fits;
  logic [7:0]         nb_sum;
  logic [POS_W:0]     al_pos, al_rm, al_rnd;
  logic [7:0]         sh;
  logic [ACC_W-1:0]   shifted;
  logic [63:0]        mask;
  logic               wr_en, out_load;

  // cursor arithmetic for the command at the queue head
  assign need   = NEED_W'({pos_q, 3'b000}) + NEED_W'(ph_q) + NEED_W'(cmd_i.bit_count);
  assign have   = NEED_W'({len_q, 3'b000});
  assign fits   = need <= have;
  assign nb_sum = 8'(ph_q) + 8'(cmd_i.bit_count) + 8'd7;
  assign al_pos = {1'b0, pos_q} + (POS_W+1)'(ph_q != 3'd0);
  assign al_rm  = (POS_W+1)'((4'd1 << cmd_i.align_log2) - 4'd1);
  assign al_rnd = (al_pos + al_rm) & ~al_rm;

  // cursor after a read that just completed
  assign need_q = NEED_W'({pos_q, 3'b000}) + NEED_W'(ph_q) + NEED_W'(cnt_q);

  // final extraction from the byte window
  assign sh      = 8'({nb_q, 3'b000}) - 8'(ph_q) - 8'(cnt_q);
  assign shifted = acc_q >> sh;
  assign mask    = (cnt_q >= CNT_W'(MAX_BITS)) ? '1 : ((64'd1 << cnt_q[5:0]) - 64'd1);

  assign out_load = (state_q == S_DONE) && (!out_vld_q || !out_stall_i);

  // command sequencer
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    pos_d     = pos_q;
    ph_d      = ph_q;
    stat_d    = stat_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    move_d    = move_q;
    nb_d      = nb_q;
    cmd_pop_o = 1'b0;
    wr_en     = 1'b0;
    fetch_go  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          stat_d    = ST_OK;
          val_d     = '0;
          state_d   = S_DONE;
          case (cmd_i.kind)
            K_APPEND: begin
              if (len_q >= POS_W'(STORE_DEPTH)) begin
                stat_d = ST_FULL;
              end else begin
                wr_en = 1'b1;
                len_d = len_q + POS_W'(1);
              end
            end
            K_READ, K_PEEK: begin
              if (pos_q >= len_q || cmd_i.bit_count > CNT_W'(MAX_BITS) || !fits) begin
                stat_d = ST_OOB;
              end else if (cmd_i.bit_count != '0) begin
                cnt_d    = cmd_i.bit_count;
                move_d   = cmd_i.kind == K_READ;
                nb_d     = nb_sum[6:3];
                fetch_go = 1'b1;
                state_d  = S_FETCH;
              end
            end
            K_SKIP: begin
              if (!fits) begin
                stat_d = ST_OOB;
              end else begin
                pos_d = need[NEED_W-2:3];
                ph_d  = need[2:0];
              end
            end
            K_ALIGN: begin
              ph_d = 3'd0;
              if (al_rnd > {1'b0, len_q}) pos_d = len_q;
              else                        pos_d = al_rnd[POS_W-1:0];
              if (pos_d < pos_q)          pos_d = pos_q;
            end
            K_CLEAR: begin
              len_d = '0;
              pos_d = '0;
              ph_d  = 3'd0;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (rd_vld_q && (rcv_q + 4'd1 == nb_q)) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        val_d = shifted[63:0] & mask;
        if (move_q) begin
          pos_d = need_q[NEED_W-2:3];
          ph_d  = need_q[2:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      pos_q     <= '0;
      ph_q      <= 3'd0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      iss_q     <= '0;
      rcv_q     <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      ph_q    <= ph_d;
      // byte fetch counters
      if (fetch_go) begin
        iss_q    <= '0;
        rcv_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (state_q == S_FETCH) begin
        rd_vld_q <= iss_q < nb_q;
        if (iss_q < nb_q) iss_q <= iss_q + 4'd1;
        if (rd_vld_q)     rcv_q <= rcv_q + 4'd1;
      end else begin
        rd_vld_q <= 1'b0;
      end
      // output register
      if (out_load)         out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    move_q <= move_d;
    nb_q   <= nb_d;
    if (fetch_go) acc_q <= '0;
    else if (state_q == S_FETCH && rd_vld_q) acc_q <= {acc_q[ACC_W-9:0], rd_data_q};
    if (out_load) begin
      out_q.value         <= val_q;
      out_q.status        <= stat_q;
      out_q.byte_position <= pos_q;
      out_q.bit_offset    <= ph_q;
      out_q.at_end        <= pos_q >= len_q;
    end
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[len_q[ADDR_W-1:0]] <= cmd_i.byte_in;
    rd_data_q <= mem[ADDR_W'(pos_q + POS_W'(iss_q))];
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ tb/sv/msb_first_bit_reader_tb.sv @@
`timescale 1ns / 1ps

module msb_first_bit_reader_tb;
  import mbr_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  mbr_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  mbr_out_t out_data_o;

  msb_first_bit_reader dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // shadow of the bit reader state
  logic [7:0]  shadow_bytes [STORE_DEPTH];
  int unsigned shadow_len;
  int unsigned shadow_pos;
  int unsigned shadow_phase;

  // generator view of the state, tracked alongside the queued items
  int unsigned gen_len;
  int unsigned gen_pos;
  int unsigned gen_phase;

  mbr_in_t  pending_items [$];
  mbr_out_t expected_results [$];
  int       error_count;
  int       sent_count;
  int       cycle_count;
  int       send_idle_pct;
  int       recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // bits from the current cursor, msb first
  function automatic logic [63:0] gather_bits(int unsigned count);
    logic [63:0] acc;
    int unsigned bp;
    acc = '0;
    bp = shadow_pos * 8 + shadow_phase;
    for (int unsigned i = 0; i < count; i++) begin
      acc = {acc[62:0], shadow_bytes[(bp + i) >> 3][7 - ((bp + i) & 7)]};
    end
    return acc;
  endfunction

  // compute the result of one accepted transaction and update the shadow
  function automatic mbr_out_t predict_step(mbr_in_t item);
    mbr_out_t    res;
    int unsigned cnt;
    int unsigned total;
    int unsigned stride;
    int unsigned npos;
    bit          fit;
    res = '0;
    res.status = ST_OK;
    cnt = item.bit_count;
    fit = (shadow_pos * 8 + shadow_phase + cnt) <= shadow_len * 8;
    total = shadow_pos * 8 + shadow_phase + cnt;
    case (item.op)
      OPC_APPEND: begin
        if (shadow_len >= STORE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_bytes[shadow_len] = item.byte_in;
          shadow_len++;
        end
      end
      OPC_READ, OPC_PEEK: begin
        if (shadow_pos >= shadow_len || cnt > MAX_BITS || !fit) begin
          res.status = ST_OOB;
        end else begin
          res.value = gather_bits(cnt);
          if (item.op == OPC_READ) begin
            shadow_pos = total >> 3;
            shadow_phase = total & 7;
          end
        end
      end
      OPC_SKIP: begin
        if (!fit) begin
          res.status = ST_OOB;
        end else begin
          shadow_pos = total >> 3;
          shadow_phase = total & 7;
        end
      end
      OPC_ALIGN: begin
        stride = 1 << item.align_log2;
        npos = shadow_pos;
        if (shadow_phase != 0) begin
          shadow_phase = 0;
          npos++;
        end
        npos = (npos + stride - 1) & ~(stride - 1);
        if (npos > shadow_len) begin
          npos = (shadow_pos >= shadow_len && shadow_phase == 0 && npos < shadow_pos) ?
                 shadow_pos : shadow_len;
        end
        if (npos < shadow_pos) npos = shadow_pos;
        shadow_pos = npos;
      end
      OPC_CLEAR: begin
        shadow_len = 0;
        shadow_pos = 0;
        shadow_phase = 0;
      end
      default: begin
      end
    endcase
    res.byte_position = shadow_pos[POS_W-1:0];
    res.bit_offset = shadow_phase[2:0];
    res.at_end = shadow_pos >= shadow_len;
    return res;
  endfunction

  // queue one item and update the generator view of the state
  task automatic push_item(input logic [2:0] op, input logic [7:0] b,
                           input logic [6:0] cnt, input logic [1:0] al);
    mbr_in_t item;
    int unsigned total;
    int unsigned stride;
    item.op = op;
    item.byte_in = b;
    item.bit_count = cnt;
    item.align_log2 = al;
    pending_items.push_back(item);
    total = gen_pos * 8 + gen_phase + cnt;
    case (op)
      OPC_APPEND: if (gen_len < STORE_DEPTH) gen_len++;
      OPC_READ, OPC_SKIP: begin
        if (total <= gen_len * 8 && (op == OPC_SKIP || (gen_pos < gen_len && cnt <= MAX_BITS))) begin
          gen_pos = total >> 3;
          gen_phase = total & 7;
        end
      end
      OPC_ALIGN: begin
        stride = 1 << al;
        if (gen_phase != 0) begin
          gen_phase = 0;
          gen_pos++;
        end
        gen_pos = (gen_pos + stride - 1) & ~(stride - 1);
        if (gen_pos > gen_len) gen_pos = gen_len;
      end
      OPC_CLEAR: begin
        gen_len = 0;
        gen_pos = 0;
        gen_phase = 0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'($urandom_range(0, 127));
    if (r < 4) return 7'($urandom_range(0, 64));
    return 7'($urandom_range(0, 16));
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_step(in_data_i));
        sent_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycle_count++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.value, 64'd0);
        end else begin
          mbr_out_t want;
          want = expected_results.pop_front();
          if (out_data_o.value !== want.value)
            report_mismatch("value", out_data_o.value, want.value);
          if (out_data_o.status !== want.status)
            report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
          if (out_data_o.byte_position !== want.byte_position)
            report_mismatch("byte_position", 64'(out_data_o.byte_position),
                            64'(want.byte_position));
          if (out_data_o.bit_offset !== want.bit_offset)
            report_mismatch("bit_offset", 64'(out_data_o.bit_offset), 64'(want.bit_offset));
          if (out_data_o.at_end !== want.at_end)
            report_mismatch("at_end", 64'(out_data_o.at_end), 64'(want.at_end));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_count > 600000) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int n_items;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    error_count = 0;
    sent_count = 0;
    cycle_count = 0;
    shadow_len = 0;
    shadow_pos = 0;
    shadow_phase = 0;
    gen_len = 0;
    gen_pos = 0;
    gen_phase = 0;
    send_idle_pct = 18;
    recv_idle_pct = 86;

    // directed: ops at empty store, extremes of fields, end cases
    push_item(OPC_READ, 8'h00, 7'd0, 2'd0);
    push_item(OPC_PEEK, 8'h00, 7'd1, 2'd0);
    push_item(OPC_SKIP, 8'h00, 7'd0, 2'd3);
    push_item(OPC_ALIGN, 8'h00, 7'd0, 2'd3);
    for (int i = 0; i < 9; i++) push_item(OPC_APPEND, (i % 2) ? 8'hff : 8'h5a, 7'd0, 2'd0);
    push_item(OPC_READ, 8'h00, 7'd127, 2'd0);
    push_item(OPC_PEEK, 8'h00, 7'd64, 2'd0);
    push_item(OPC_READ, 8'h00, 7'd0, 2'd0);
    push_item(OPC_READ, 8'h00, 7'd3, 2'd0);
    push_item(OPC_PEEK, 8'h00, 7'd64, 2'd0);
    push_item(OPC_ALIGN, 8'h00, 7'd0, 2'd2);
    push_item(OPC_SKIP, 8'h00, 7'd100, 2'd0);
    push_item(OPC_READ, 8'h00, 7'd32, 2'd0);
    push_item(3'd6, 8'hff, 7'd127, 2'd3);
    push_item(3'd7, 8'h00, 7'd0, 2'd0);
    push_item(OPC_ALIGN, 8'h00, 7'd0, 2'd3);
    push_item(OPC_CLEAR, 8'h00, 7'd0, 2'd0);

    // random: a mix of appends, reads, peeks, skips, aligns, clears and undefined ops
    n_items = 0;
    while (n_items < 1725) begin
      r = $urandom_range(0, 99);
      if (r < 30) push_item(OPC_APPEND, 8'($urandom), 7'd0, 2'($urandom));
      else if (r < 55) push_item(OPC_READ, 8'($urandom), pick_count(), 2'($urandom));
      else if (r < 72) push_item(OPC_PEEK, 8'($urandom), pick_count(), 2'($urandom));
      else if (r < 84) push_item(OPC_SKIP, 8'($urandom), pick_count(), 2'($urandom));
      else if (r < 94) push_item(OPC_ALIGN, 8'($urandom), pick_count(), 2'($urandom));
      else if (r < 97) push_item(OPC_CLEAR, 8'($urandom), pick_count(), 2'($urandom));
      else push_item(3'($urandom_range(6, 7)), 8'($urandom), pick_count(), 2'($urandom));
      n_items++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idling phases by items accepted
    wait (sent_count >= 580);
    send_idle_pct = 86;
    recv_idle_pct = 18;
    wait (sent_count >= 1160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
